// ----- src/adsr_pkg.sv -----
// ----------------------------------------------------------------------------
// adsr_pkg: shared types and constants for the ADSR envelope generator
// Register map of the configuration port.
// ----------------------------------------------------------------------------
`default_nettype none

package adsr_pkg;

    // Width of the configuration register index
    localparam int CFG_IDX_W = 3;

    typedef logic [CFG_IDX_W-1:0] t_cfg_idx;

    // Configuration register map
    localparam t_cfg_idx CFG_ATTACK_STEP   = 3'd0;
    localparam t_cfg_idx CFG_DECAY_FACTOR  = 3'd1;
    localparam t_cfg_idx CFG_SUSTAIN_LEVEL = 3'd2;
    localparam t_cfg_idx CFG_HOLD_SAMPLES  = 3'd3;
    localparam t_cfg_idx CFG_RELEASE_STEP  = 3'd4;
    localparam t_cfg_idx CFG_TOTAL_SAMPLES = 3'd5;

    // Register reset values (truncated to the register widths in the RTL)
    localparam logic [31:0] RST_UNIT_STEP = 32'd65536;
    localparam logic [31:0] RST_SAMPLES   = 32'd44100;

endpackage : adsr_pkg

`default_nettype wire

// ----- src/adsr_envelope_generator_unit.sv -----
// ----------------------------------------------------------------------------
// adsr_envelope_generator_unit: linear attack, exponential decay, linear release
// One tick beat in, one envelope sample beat out, unsigned Q1.FRAC_BITS level.
// ----------------------------------------------------------------------------
// The block takes one tick beat per clock while o_in_stall is low; each taken
// tick's sample beat follows in the next cycle. The whole per-sample update (one
// (FRAC_BITS+1) x FRAC_BITS multiply for the decay curve, plus the attack and
// release add/subtract) sits between the envelope state registers and the
// output register, so the envelope state is ready for the next tick in the
// following cycle. The output register decouples the two sides: a new tick is
// taken whenever the output register is empty or its sample is taken in the
// same cycle. A restart tick clears the level and counters, enters attack and
// yields the first sample of the new envelope. Once total_samples samples have
// been produced the block answers level 0, active 0 until the next restart.
// Configuration writes are taken every cycle and apply from the next tick.
`default_nettype none

module adsr_envelope_generator_unit
    import adsr_pkg::*;
#(
    parameter int FRAC_BITS  = 16,
    parameter int COUNT_BITS = 20,
    localparam int LVL_W     = FRAC_BITS + 1,
    localparam int CFG_W     = (LVL_W > COUNT_BITS) ? LVL_W : COUNT_BITS
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,

    // configuration write channel
    input  wire logic                  i_cfg_valid,
    output logic                       o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]      i_cfg_data,

    // tick input channel
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire logic                  i_restart,

    // sample output channel
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output logic [LVL_W-1:0]           o_envelope_level,
    output logic                       o_active
);

    localparam int PROD_W = LVL_W + FRAC_BITS;
    localparam int EXT_W  = LVL_W + 1;

    localparam logic [LVL_W-1:0]      LVL_MAX   = {LVL_W{1'b1}};
    localparam logic [LVL_W-1:0]      LVL_ONE   = LVL_W'(1) << FRAC_BITS;
    localparam logic [COUNT_BITS-1:0] CNT_MAX   = {COUNT_BITS{1'b1}};
    localparam logic [PROD_W:0]       RND_UP    = (PROD_W + 1)'({FRAC_BITS{1'b1}});

    typedef enum logic [1:0] {
        PH_ATTACK  = 2'd0,
        PH_DECAY   = 2'd1,
        PH_RELEASE = 2'd2,
        PH_IDLE    = 2'd3
    } t_phase;

    // configuration registers
    logic [LVL_W-1:0]      r_attack_step;
    logic [FRAC_BITS-1:0]  r_decay_factor;
    logic [LVL_W-1:0]      r_sustain_level;
    logic [COUNT_BITS-1:0] r_hold_samples;
    logic [LVL_W-1:0]      r_release_step;
    logic [COUNT_BITS-1:0] r_total_samples;

    // envelope state
    t_phase                r_phase, n_phase;
    logic [LVL_W-1:0]      r_level, n_level;
    logic [COUNT_BITS-1:0] r_hold, n_hold;
    logic [COUNT_BITS-1:0] r_idx, n_idx;

    // output register
    logic                  r_out_valid;
    logic [LVL_W-1:0]      r_out_level;
    logic                  r_out_active;
    logic                  n_active;

    logic                  w_in_acc;
    t_phase                w_phase;
    logic [LVL_W-1:0]      w_level;
    logic [COUNT_BITS-1:0] w_hold;
    logic [COUNT_BITS-1:0] w_idx;
    logic [EXT_W-1:0]      w_att_sum;
    logic                  w_sus_ge;
    logic [LVL_W-1:0]      w_diff;
    logic [PROD_W-1:0]     w_prod;
    logic [PROD_W:0]       w_prod_rnd;
    logic [EXT_W-1:0]      w_dec_res;
    logic [LVL_W-1:0]      w_dec_level;
    logic [COUNT_BITS-1:0] w_hold_inc;

    // take a tick when the output register is free or drains this cycle
    assign o_in_stall  = r_out_valid & i_out_stall;
    assign w_in_acc    = i_in_valid & ~o_in_stall;
    assign o_cfg_ready = 1'b1;

    assign o_out_valid      = r_out_valid;
    assign o_envelope_level = r_out_level;
    assign o_active         = r_out_active;

    // apply a restart before the update
    always_comb begin
        w_phase = i_restart ? PH_ATTACK : r_phase;
        w_level = i_restart ? '0 : r_level;
        w_hold  = i_restart ? '0 : r_hold;
        w_idx   = i_restart ? '0 : r_idx;
    end

    // attack: saturating add
    assign w_att_sum = {1'b0, w_level} + {1'b0, r_attack_step};

    // decay: move toward sustain by the factor, floor of the product below sustain, ceiling above it
    always_comb begin
        w_sus_ge   = (r_sustain_level >= w_level);
        w_diff     = w_sus_ge ? (r_sustain_level - w_level) : (w_level - r_sustain_level);
        w_prod     = PROD_W'(w_diff) * PROD_W'(r_decay_factor);
        w_prod_rnd = {1'b0, w_prod} + RND_UP;
        if (w_sus_ge) begin
            w_dec_res = {1'b0, r_sustain_level} - {1'b0, w_prod[PROD_W-1:FRAC_BITS]};
        end else begin
            w_dec_res = {1'b0, r_sustain_level} + w_prod_rnd[PROD_W:FRAC_BITS];
        end
        w_dec_level = w_dec_res[LVL_W] ? LVL_MAX : w_dec_res[LVL_W-1:0];
        w_hold_inc  = (w_hold != CNT_MAX) ? (w_hold + 1'b1) : w_hold;
    end

    // next envelope state and sample
    always_comb begin
        n_phase  = w_phase;
        n_level  = w_level;
        n_hold   = w_hold;
        n_idx    = w_idx + 1'b1;
        n_active = 1'b1;
        if (w_phase == PH_IDLE || w_idx >= r_total_samples) begin
            n_phase  = PH_IDLE;
            n_level  = '0;
            n_idx    = w_idx;
            n_active = 1'b0;
        end else begin
            unique case (w_phase)
                PH_ATTACK: begin
                    n_level = w_att_sum[LVL_W] ? LVL_MAX : w_att_sum[LVL_W-1:0];
                    if (w_att_sum >= {1'b0, LVL_ONE}) begin
                        n_phase = PH_DECAY;
                    end
                end
                PH_DECAY: begin
                    n_level = w_dec_level;
                    n_hold  = w_hold_inc;
                    if (w_hold_inc >= r_hold_samples) begin
                        n_phase = PH_RELEASE;
                    end
                end
                PH_RELEASE: begin
                    n_level = (w_level > r_release_step) ? (w_level - r_release_step) : '0;
                end
                default: begin
                    n_level = '0;
                end
            endcase
        end
    end

    // hold configuration, envelope state and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_attack_step   <= LVL_W'(RST_UNIT_STEP);
            r_decay_factor  <= '0;
            r_sustain_level <= LVL_W'(RST_UNIT_STEP);
            r_hold_samples  <= COUNT_BITS'(RST_SAMPLES);
            r_release_step  <= LVL_W'(RST_UNIT_STEP);
            r_total_samples <= COUNT_BITS'(RST_SAMPLES);
            r_phase         <= PH_IDLE;
            r_level         <= '0;
            r_hold          <= '0;
            r_idx           <= '0;
            r_out_valid     <= 1'b0;
            r_out_level     <= '0;
            r_out_active    <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (i_cfg_index)
                    CFG_ATTACK_STEP:   r_attack_step   <= i_cfg_data[LVL_W-1:0];
                    CFG_DECAY_FACTOR:  r_decay_factor  <= i_cfg_data[FRAC_BITS-1:0];
                    CFG_SUSTAIN_LEVEL: r_sustain_level <= i_cfg_data[LVL_W-1:0];
                    CFG_HOLD_SAMPLES:  r_hold_samples  <= i_cfg_data[COUNT_BITS-1:0];
                    CFG_RELEASE_STEP:  r_release_step  <= i_cfg_data[LVL_W-1:0];
                    CFG_TOTAL_SAMPLES: r_total_samples <= i_cfg_data[COUNT_BITS-1:0];
                    default: ;
                endcase
            end
            if (w_in_acc) begin
                r_phase      <= n_phase;
                r_level      <= n_level;
                r_hold       <= n_hold;
                r_idx        <= n_idx;
                r_out_valid  <= 1'b1;
                r_out_level  <= n_level;
                r_out_active <= n_active;
            end else if (!i_out_stall) begin
                r_out_valid  <= 1'b0;
            end
        end
    end

`ifndef SYNTHESIS
    // an inactive sample carries a zero level
    a_inactive_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_active) |-> (r_out_level == '0))
        else $error("inactive sample with nonzero level");

    // an idle envelope stays silent until a restart
    a_idle_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !i_restart && r_phase == PH_IDLE) |=>
            (r_out_valid && !r_out_active && r_phase == PH_IDLE))
        else $error("idle envelope produced an active sample");

    // envelope state advances only on a taken tick
    a_state_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_in_acc |=> ($stable(r_idx) && $stable(r_level) && $stable(r_hold)))
        else $error("envelope state changed without a tick");

    // attack never lowers the level
    a_attack_rise: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !i_restart && r_phase == PH_ATTACK && r_idx < r_total_samples)
            |=> (r_level >= $past(r_level)))
        else $error("level fell during attack");

    // release never raises the level
    a_release_fall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_in_acc && !i_restart && r_phase == PH_RELEASE) |=> (r_level <= $past(r_level)))
        else $error("level rose during release");
`endif

endmodule : adsr_envelope_generator_unit

`default_nettype wire

// ----- bench/testbench.sv -----
// ----------------------------------------------------------------------------
// testbench: self-checking bench for adsr_envelope_generator_unit
// Drives tick beats with random gaps and holds off sample beats at random.
// A cycle-free model of the envelope predicts every sample beat. Every phase
// after the first reprograms the registers while the block is idle. Directed
// phases come first, then random envelopes, with a share of noisy restart patterns.
// ----------------------------------------------------------------------------
`default_nettype none

module testbench;
    import adsr_pkg::*;

    localparam int LVL_W = 17;
    localparam int CNT_W = 20;
    localparam int CFG_W = 20;
    localparam logic [63:0] LEVEL_MAX = 64'd131071;
    localparam logic [63:0] UNIT_LEVEL = 64'd65536;
    localparam logic [63:0] COUNT_MAX = 64'd1048575;
    localparam int RANDOM_TICKS = 1450;
    localparam int SETTLE_CYCLES = 20;

    // Indexes past the register map; writes to them must be ignored
    localparam t_cfg_idx CFG_SPARE_LO = 3'd6;
    localparam t_cfg_idx CFG_SPARE_HI = 3'd7;

    typedef enum logic [1:0] {
        PH_ATTACK  = 2'd0,
        PH_DECAY   = 2'd1,
        PH_RELEASE = 2'd2,
        PH_IDLE    = 2'd3
    } t_env_phase;

    typedef struct packed {
        logic [LVL_W-1:0] level;
        logic             active;
    } t_sample;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_valid = 1'b0;
    t_cfg_idx         cfg_index = CFG_ATTACK_STEP;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             tick_valid = 1'b0;
    logic             tick_restart = 1'b0;
    logic             out_stall = 1'b0;

    wire logic             cfg_ready;
    wire logic             tick_stall;
    wire logic             out_valid;
    wire logic [LVL_W-1:0] envelope_level;
    wire logic             active;

    adsr_envelope_generator_unit DUT (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_cfg_valid      (cfg_valid),
        .o_cfg_ready      (cfg_ready),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_in_valid       (tick_valid),
        .o_in_stall       (tick_stall),
        .i_restart        (tick_restart),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_envelope_level (envelope_level),
        .o_active         (active)
    );

    // Generate the clock
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Envelope model: registers and state
    logic [LVL_W-1:0] attack_step_m;
    logic [15:0]      decay_k_m;
    logic [LVL_W-1:0] sustain_m;
    logic [CNT_W-1:0] hold_m;
    logic [LVL_W-1:0] release_step_m;
    logic [CNT_W-1:0] total_m;
    t_env_phase       phase_m;
    logic [LVL_W-1:0] level_m;
    logic [CNT_W-1:0] hold_cnt_m;
    logic [CNT_W-1:0] index_m;

    logic tick_q[$];
    t_sample sample_q[$];
    int fail_cnt = 0;
    logic quiet = 1'b0;
    int tick_gap = 0;
    int stall_left = 0;

    // Step the level toward sustain; floor the product below sustain, round it up above
    function automatic logic [LVL_W-1:0] decay_toward(input logic [LVL_W-1:0] lvl);
        logic [63:0] sus;
        logic [63:0] t;
        logic [63:0] res;
        sus = sustain_m;
        if (sus >= lvl) begin
            t = ((sus - lvl) * decay_k_m) >> 16;
            res = sus - t;
        end else begin
            t = ((lvl - sus) * decay_k_m + 64'd65535) >> 16;
            res = sus + t;
        end
        if (res > LEVEL_MAX) res = LEVEL_MAX;
        return res[LVL_W-1:0];
    endfunction

    // Advance the envelope by one tick and return the sample it yields
    function automatic t_sample advance_envelope(input logic restart_bit);
        t_sample s;
        logic [63:0] acc;
        if (restart_bit) begin
            phase_m = PH_ATTACK;
            level_m = '0;
            hold_cnt_m = '0;
            index_m = '0;
        end
        if (phase_m == PH_IDLE || index_m >= total_m) begin
            phase_m = PH_IDLE;
            level_m = '0;
            s.level = '0;
            s.active = 1'b0;
            return s;
        end
        case (phase_m)
            PH_ATTACK: begin
                acc = {47'd0, level_m} + {47'd0, attack_step_m};
                if (acc > LEVEL_MAX) acc = LEVEL_MAX;
                level_m = acc[LVL_W-1:0];
                if (acc >= UNIT_LEVEL) phase_m = PH_DECAY;
            end
            PH_DECAY: begin
                level_m = decay_toward(level_m);
                if ({44'd0, hold_cnt_m} < COUNT_MAX) hold_cnt_m = hold_cnt_m + 1'b1;
                if (hold_cnt_m >= hold_m) phase_m = PH_RELEASE;
            end
            default: begin
                if (level_m > release_step_m) level_m = level_m - release_step_m;
                else level_m = '0;
            end
        endcase
        index_m = index_m + 1'b1;
        s.level = level_m;
        s.active = 1'b1;
        return s;
    endfunction

    // Mirror one accepted register write
    function automatic void apply_cfg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        case (idx)
            CFG_ATTACK_STEP:   attack_step_m = data[LVL_W-1:0];
            CFG_DECAY_FACTOR:  decay_k_m = data[15:0];
            CFG_SUSTAIN_LEVEL: sustain_m = data[LVL_W-1:0];
            CFG_HOLD_SAMPLES:  hold_m = data;
            CFG_RELEASE_STEP:  release_step_m = data[LVL_W-1:0];
            CFG_TOTAL_SAMPLES: total_m = data;
            default: ;
        endcase
    endfunction

    // Idle length: mostly none, some short, a few long
    function automatic int pick_gap();
        int r;
        if (quiet) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    task automatic note_fail(input string msg);
        fail_cnt++;
        if (fail_cnt <= 10) $display("ERROR: %s", msg);
    endtask

    // Driver: take tick beats from the pending queue, predict on acceptance
    always @(posedge clk) begin : tick_driver
        logic nxt_valid;
        logic nxt_restart;
        nxt_valid = tick_valid;
        nxt_restart = tick_restart;
        if (!rst_n) begin
            nxt_valid = 1'b0;
        end else begin
            if (tick_valid && !tick_stall) begin
                sample_q.push_back(advance_envelope(tick_restart));
                nxt_valid = 1'b0;
            end
            if (!nxt_valid) begin
                if (tick_gap > 0) begin
                    tick_gap--;
                end else if (tick_q.size() > 0) begin
                    nxt_restart = tick_q.pop_front();
                    nxt_valid = 1'b1;
                    tick_gap = pick_gap();
                end
            end
        end
        tick_valid <= nxt_valid;
        tick_restart <= nxt_restart;
    end

    // Monitor: check sample beats against the oldest prediction, stall at random
    always @(posedge clk) begin : sample_monitor
        t_sample want;
        logic nxt_stall;
        nxt_stall = 1'b0;
        if (rst_n) begin
            if (out_valid && !out_stall) begin
                if (sample_q.size() == 0) begin
                    note_fail($sformatf("sample beat with nothing expected: level %0d active %0b",
                                        envelope_level, active));
                end else begin
                    want = sample_q.pop_front();
                    if (envelope_level !== want.level || active !== want.active)
                        note_fail($sformatf(
                            "sample mismatch: level exp %0d got %0d, active exp %0b got %0b",
                            want.level, envelope_level, want.active, active));
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                nxt_stall = 1'b1;
            end else begin
                stall_left = pick_gap();
            end
        end
        out_stall <= nxt_stall;
    end

    // Wait until no tick is pending and no sample is outstanding
    task automatic wait_drain();
        @(negedge clk);
        while (tick_q.size() != 0 || tick_valid || sample_q.size() != 0) @(negedge clk);
    endtask

    // Write one register; call right after a rising edge
    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        apply_cfg(idx, data);
    endtask

    // Drain, then program all six registers
    task automatic program_envelope(input logic [CFG_W-1:0] atk, input logic [CFG_W-1:0] dk,
                                    input logic [CFG_W-1:0] sus, input logic [CFG_W-1:0] hold,
                                    input logic [CFG_W-1:0] rel, input logic [CFG_W-1:0] total,
                                    input logic stray);
        wait_drain();
        @(posedge clk);
        if (stray) begin
            write_reg(CFG_SPARE_LO, CFG_W'($urandom));
            write_reg(CFG_SPARE_HI, CFG_W'($urandom));
        end
        write_reg(CFG_ATTACK_STEP, atk);
        write_reg(CFG_DECAY_FACTOR, dk);
        write_reg(CFG_SUSTAIN_LEVEL, sus);
        write_reg(CFG_HOLD_SAMPLES, hold);
        write_reg(CFG_RELEASE_STEP, rel);
        write_reg(CFG_TOTAL_SAMPLES, total);
        cfg_valid <= 1'b0;
    endtask

    // Queue a restart (or a plain tick) followed by plain ticks
    task automatic queue_ticks(input int n, input logic first_restart);
        tick_q.push_back(first_restart);
        for (int i = 1; i < n; i++) tick_q.push_back(1'b0);
    endtask

    // Stimulus: directed phases, then random envelopes
    initial begin
        int sent;
        int n;
        int r;
        logic noisy;
        logic [CFG_W-1:0] atk, dk, sus, hold, rel, total;

        attack_step_m = RST_UNIT_STEP[LVL_W-1:0];
        decay_k_m = '0;
        sustain_m = RST_UNIT_STEP[LVL_W-1:0];
        hold_m = RST_SAMPLES[CNT_W-1:0];
        release_step_m = RST_UNIT_STEP[LVL_W-1:0];
        total_m = RST_SAMPLES[CNT_W-1:0];
        phase_m = PH_IDLE;
        level_m = '0;
        hold_cnt_m = '0;
        index_m = '0;

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        // Idle after reset answers zero until a restart
        queue_ticks(2, 1'b0);
        queue_ticks(2, 1'b1);
        // Instant attack, slowest decay toward a zero sustain, no hold, then the envelope ends
        program_envelope(20'd65536, 20'd65535, 20'd0, 20'd0, 20'd65536, 20'd4, 1'b1);
        queue_ticks(5, 1'b1);
        // Zero length: even the restart tick is inactive
        program_envelope(20'd0, 20'd0, 20'd65536, 20'd0, 20'd0, 20'd0, 1'b0);
        queue_ticks(2, 1'b1);
        // Zero attack step never leaves attack
        program_envelope(20'd0, 20'd0, 20'd65536, 20'd0, 20'd0, 20'd100, 1'b0);
        queue_ticks(3, 1'b1);
        // Overshoot above sustain, then restart mid envelope
        program_envelope(20'd40000, 20'd40000, 20'd30000, 20'd2, 20'd20000, 20'd20, 1'b0);
        queue_ticks(5, 1'b1);
        queue_ticks(3, 1'b1);
        // Register extremes
        program_envelope(20'd131071, 20'd65535, 20'd131071, 20'hFFFFF, 20'd131071, 20'hFFFFF,
                         1'b0);
        queue_ticks(3, 1'b1);

        sent = 0;
        while (sent < RANDOM_TICKS) begin
            r = $urandom_range(0, 99);
            atk = CFG_W'((r < 5) ? 20'd0 : (r < 10) ? 20'd65536 :
                         (r < 15) ? $urandom_range(1, 255) :
                         (r < 20) ? $urandom : $urandom_range(2048, 65536));
            r = $urandom_range(0, 99);
            dk = CFG_W'((r < 10) ? 20'd0 : (r < 20) ? 20'd65535 : (r < 25) ? $urandom :
                        $urandom_range(0, 65535));
            r = $urandom_range(0, 99);
            sus = CFG_W'((r < 10) ? 20'd0 : (r < 20) ? 20'd65536 : (r < 25) ? $urandom :
                         $urandom_range(0, 65536));
            r = $urandom_range(0, 99);
            hold = CFG_W'((r < 10) ? 20'd0 : (r < 15) ? 20'hFFFFF : (r < 20) ? $urandom :
                          $urandom_range(0, 30));
            r = $urandom_range(0, 99);
            rel = CFG_W'((r < 10) ? 20'd0 : (r < 20) ? 20'd65536 : (r < 25) ? $urandom :
                         $urandom_range(1, 65536));
            r = $urandom_range(0, 99);
            total = CFG_W'((r < 5) ? 20'd0 : (r < 10) ? 20'hFFFFF : (r < 13) ? $urandom :
                           $urandom_range(1, 120));
            program_envelope(atk, dk, sus, hold, rel, total, $urandom_range(0, 3) == 0);
            quiet = ($urandom_range(0, 3) == 0);
            noisy = ($urandom_range(0, 9) == 0);
            n = $urandom_range(30, 90);
            // Mostly whole envelopes with rare retriggers; some phases are restart noise
            tick_q.push_back(noisy ? 1'($urandom_range(0, 1)) : 1'b1);
            for (int i = 1; i < n; i++)
                tick_q.push_back(noisy ? 1'($urandom_range(0, 1)) : ($urandom_range(0, 39) == 0));
            sent += n;
        end

        wait_drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sample_q.size() != 0)
            note_fail($sformatf("%0d expected samples never arrived", sample_q.size()));
        if (fail_cnt == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Stop a hung run
    initial begin
        #20000000;
        $display("*** FAILED ***");
        $finish;
    end

endmodule : testbench

`default_nettype wire
